### hdl/ult_pkg.sv
// Shared constants, codes and the result type of the unordered list table.
`default_nettype none

package ult_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 7;
    localparam int VAL_W  = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT     = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAPACITY_RST  = CNT_W'(64);

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_SEARCH = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] found_index;
        logic [CNT_W-1:0]  entry_count;
    } t_result;

endpackage

`default_nettype wire

### hdl/ult_if.sv
// Request and response channel interfaces of the unordered list table.
`default_nettype none

interface ult_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      func;
    logic signed [ult_pkg::VAL_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface ult_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [ult_pkg::ADDR_W-1:0]        found_index;
    logic [ult_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, output status, output found_index, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input entry_count,
                    output ready);
endinterface

`default_nettype wire

### hdl/ult_core.sv
// Table memory, entry count and the scan/swap sequencer of the unordered list table.
`default_nettype none

module ult_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ult_pkg::CNT_W-1:0]   i_capacity,
    ult_req_if.sink                          i_req,
    output logic                             o_res_valid,
    output ult_pkg::t_result                 o_res,
    input  wire logic                        i_res_ready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SWAP = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [ult_pkg::VAL_W-1:0]  r_mem [ult_pkg::DEPTH];
    logic [ult_pkg::VAL_W-1:0]  r_rd_data;

    logic [2:0]                 r_state, n_state;
    logic [1:0]                 r_func, n_func;
    logic [ult_pkg::VAL_W-1:0]  r_value, n_value;
    logic [ult_pkg::ADDR_W-1:0] r_idx, n_idx;
    logic [ult_pkg::CNT_W-1:0]  r_count, n_count;
    ult_pkg::t_result           r_res, n_res;

    logic                       mem_we;
    logic [ult_pkg::ADDR_W-1:0] mem_wa;
    logic [ult_pkg::VAL_W-1:0]  mem_wd;
    logic                       rd_en;
    logic [ult_pkg::ADDR_W-1:0] rd_addr;

    logic [ult_pkg::CNT_W-1:0]  cap_lim;
    logic [ult_pkg::CNT_W-1:0]  cnt_m1;
    logic [ult_pkg::CNT_W-1:0]  idx_p1;
    logic                       hit;

    assign cap_lim = (i_capacity > ult_pkg::DEPTH_CNT) ? ult_pkg::DEPTH_CNT : i_capacity;
    assign cnt_m1  = r_count - ult_pkg::CNT_W'(1);
    assign idx_p1  = {1'b0, r_idx} + ult_pkg::CNT_W'(1);
    assign hit     = (r_rd_data == r_value);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        n_func  = r_func;
        n_value = r_value;
        n_idx   = r_idx;
        n_count = r_count;
        n_res   = r_res;
        mem_we  = 1'b0;
        mem_wa  = r_count[ult_pkg::ADDR_W-1:0];
        mem_wd  = i_req.value;
        rd_en   = 1'b0;
        rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func  = i_req.func;
                    n_value = i_req.value;
                    n_idx   = '0;
                    n_state = S_DONE;
                    n_res   = '{status: ult_pkg::ST_OK, found_index: '0, entry_count: r_count};
                    case (i_req.func)
                        ult_pkg::FN_INSERT: begin
                            if (r_count >= cap_lim) begin
                                n_res.status = ult_pkg::ST_FULL;
                            end else begin
                                mem_we            = 1'b1;
                                n_count           = r_count + ult_pkg::CNT_W'(1);
                                n_res.entry_count = n_count;
                            end
                        end
                        ult_pkg::FN_SEARCH, ult_pkg::FN_REMOVE: begin
                            if (r_count == '0) begin
                                n_res.status = ult_pkg::ST_NOTFOUND;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // r_rd_data holds entry r_idx
                if (hit) begin
                    if (r_func == ult_pkg::FN_REMOVE) begin
                        rd_en   = 1'b1;
                        rd_addr = cnt_m1[ult_pkg::ADDR_W-1:0];
                        n_state = S_SWAP;
                    end else begin
                        n_res   = '{status: ult_pkg::ST_OK, found_index: r_idx,
                                    entry_count: r_count};
                        n_state = S_DONE;
                    end
                end else if (idx_p1 == r_count) begin
                    n_res   = '{status: ult_pkg::ST_NOTFOUND, found_index: '0,
                                entry_count: r_count};
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = idx_p1[ult_pkg::ADDR_W-1:0];
                    n_idx   = idx_p1[ult_pkg::ADDR_W-1:0];
                end
            end
            S_SWAP: begin
                // move the last entry into the matched slot
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_rd_data;
                n_count = cnt_m1;
                n_res   = '{status: ult_pkg::ST_OK, found_index: r_idx, entry_count: cnt_m1};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func  <= n_func;
        r_value <= n_value;
        r_idx   <= n_idx;
        r_res   <= n_res;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ult_pkg::DEPTH_CNT)
        else $error("entry count exceeds table depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> ({1'b0, r_idx} < r_count))
        else $error("scan index beyond entry count");

    a_swap_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP) |=> (r_count == $past(r_count) - ult_pkg::CNT_W'(1)))
        else $error("remove did not shrink the count by one");

endmodule

`default_nettype wire

### hdl/unordered_list_table.sv
// Top level of the unordered list table: capacity register, sequencer and response register.
//
// Table of up to 64 signed 32-bit values kept in no order, with an entry count.
// Request channel i_req (valid/ready) carries func (0 insert, 1 search, 2 remove)
// and value; one transfer on o_rsp follows each request with status, found_index
// and the entry count after the operation.
// Capacity is written through i_cfg_we/i_cfg_wdata; the user must write it only while
// the block is idle, which the block does not enforce; values above 64 act as 64.
// Sequence: an insert, an unused code or a search/remove on an empty table goes
// straight to the done state; its response passes the core result register, then the
// output register. Search and remove read one entry per cycle from the table memory;
// a hit ends the scan, a remove adds a swap that moves the last entry into the matched
// slot, a miss ends after the last entry. The next request is taken once the response
// has moved to the output register, so no request is taken while one is being scanned.
// Reset empties the table (count 0) and sets capacity to 64; the table memory
// is not cleared. When o_rsp is stalled the response is held, one more result
// can wait inside, and then requests are held off until the stall clears.
`default_nettype none

module unordered_list_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ult_pkg::CNT_W-1:0]   i_cfg_wdata,
    ult_req_if.sink                          i_req,
    ult_rsp_if.source                        o_rsp
);

    logic [ult_pkg::CNT_W-1:0] r_capacity;
    logic                      r_out_valid;
    ult_pkg::t_result          r_out;
    logic                      res_valid;
    ult_pkg::t_result          res;
    logic                      res_ready;

    assign res_ready = !r_out_valid || o_rsp.ready;

    ult_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_req       (i_req),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= ult_pkg::CAPACITY_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (res_ready) begin
                r_out_valid <= res_valid;
            end
        end
    end

    // load the response only when the output slot is free or draining
    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out.status;
    assign o_rsp.found_index = r_out.found_index;
    assign o_rsp.entry_count = r_out.entry_count;

endmodule

`default_nettype wire
